FILE: rtl/core/drlm_pkg.sv
// Shared types and constants for the dirty rectangle list merger.
// Used by drlm_clip, dirty_rect_list_merger and the test bench files; depends on nothing.
`timescale 1ns / 1ps

package drlm_pkg;

    // Command codes carried on the slave-side tuser.
    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] CFG_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_BYPASS = 2'd2;

    localparam logic [14:0] WIDTH_RESET  = 15'd320;
    localparam logic [14:0] HEIGHT_RESET = 15'd200;

    // Raw signed edges as they arrive, left in the lowest bits.
    typedef struct packed {
        logic [15:0] bottom;
        logic [15:0] right;
        logic [15:0] top;
        logic [15:0] left;
    } t_edges;

    // A stored rectangle, left in the lowest bits.
    typedef struct packed {
        logic [14:0] bottom;
        logic [14:0] right;
        logic [14:0] top;
        logic [14:0] left;
    } t_rect;

    // Result of the clip stage handed to the sequencer.
    typedef struct packed {
        logic  drop;
        t_rect rect;
    } t_clip;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLIP,
        ST_DECIDE,
        ST_SCAN,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_INSERT,
        ST_DRAIN,
        ST_EMIT
    } t_state;

endpackage

FILE: rtl/core/drlm_clip.sv
// Two-stage clip unit: orders the edges, then drops, clamps and aligns a rectangle.
// Depends on drlm_pkg.
`timescale 1ns / 1ps

module drlm_clip #(
    parameter int ALIGN_MASK_BITS = 4
) (
    input  logic            i_clk,
    input  logic            i_load,
    input  drlm_pkg::t_edges i_edges,
    input  logic [14:0]     i_width,
    input  logic [14:0]     i_height,
    output drlm_pkg::t_clip o_res
);
    import drlm_pkg::*;

    localparam logic [14:0] ALIGN_MASK = 15'((1 << ALIGN_MASK_BITS) - 1);

    logic [15:0] r_l, r_t, r_r, r_b;
    t_clip       r_res;
    t_clip       n_res;

    logic signed [16:0] w_wmax, w_hmax;
    logic [14:0]        w_lc, w_rc, w_tc, w_bc;

    // Stage one: put the edges in order.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if ($signed(i_edges.left) > $signed(i_edges.right)) begin
                r_l <= i_edges.right;
                r_r <= i_edges.left;
            end else begin
                r_l <= i_edges.left;
                r_r <= i_edges.right;
            end
            if ($signed(i_edges.top) > $signed(i_edges.bottom)) begin
                r_t <= i_edges.bottom;
                r_b <= i_edges.top;
            end else begin
                r_t <= i_edges.top;
                r_b <= i_edges.bottom;
            end
        end
    end

    assign w_wmax = $signed({2'b00, i_width}) - 17'sd1;
    assign w_hmax = $signed({2'b00, i_height}) - 17'sd1;

    // Once the rectangle is known to overlap the surface, the near edges
    // only need their sign checked and the far edges only the upper bound.
    assign w_lc = r_l[15] ? 15'd0 : r_l[14:0];
    assign w_tc = r_t[15] ? 15'd0 : r_t[14:0];
    assign w_rc = ($signed({r_r[15], r_r}) > w_wmax) ? w_wmax[14:0] : r_r[14:0];
    assign w_bc = ($signed({r_b[15], r_b}) > w_hmax) ? w_hmax[14:0] : r_b[14:0];

    always_comb begin
        n_res.drop = (i_width == 15'd0) || (i_height == 15'd0)
                     || ($signed({r_l[15], r_l}) > w_wmax) || r_r[15]
                     || ($signed({r_t[15], r_t}) > w_hmax) || r_b[15];
        n_res.rect.left   = w_lc & ~ALIGN_MASK;
        n_res.rect.right  = w_rc | ALIGN_MASK;
        n_res.rect.top    = w_tc;
        n_res.rect.bottom = w_bc;
    end

    // Stage two result; stage one holds, so this stays put until the next load while the surface size holds.
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

FILE: rtl/core/dirty_rect_list_merger.sv
// Top level of the dirty rectangle list merger: sequencer, rectangle memory,
// output register and configuration registers. Depends on drlm_pkg and drlm_clip.
`timescale 1ns / 1ps

// Usage
// Slave channel: tdata carries left, top, right, bottom (16 bits signed each),
// tuser carries the command (add or drain). Master channel: tdata carries the
// rectangle edges, tuser the whole-screen and list-empty flags, tlast marks the
// final result of a drain or of a bypass report. Configuration writes go on
// their own channel, which is always ready; the user must write only while the
// block is idle, which the block itself does not enforce. One request is
// handled at a time; o_s_tready is high only when idle. An add ends after the
// clip and a decision when the rectangle is dropped, when it collapses a full
// list or when it lands in an empty list; else it scans the entries in order,
// with a read and a write per entry moved by an insertion, then the insertion
// itself. A drain emits its entries one by one while the receiver keeps up; an
// empty drain and a bypass add emit one report each. The single memory port
// pair sets this sequencing.
// A stalled receiver holds the output register; a drain waits on it entry by
// entry, as does a bypass add, while any other finished add returns to idle regardless.
// Reset empties the list and restores a 320 by 200 surface with bypass off;
// the memory itself is not cleared.
module dirty_rect_list_merger #(
    parameter int MAX_RECTS       = 30,
    parameter int ALIGN_MASK_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave side
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // left[15:0], top[31:16], right[47:32], bottom[63:48]
    input  logic [0:0]  i_s_tuser,   // command[0]
    // master side
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // out_left[14:0], out_top[29:15], out_right[44:30],
                                     // out_bottom[59:45], zero[63:60]
    output logic [1:0]  o_m_tuser,   // whole_screen[0], list_empty[1]
    output logic        o_m_tlast,
    // configuration
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data
);
    import drlm_pkg::*;

    localparam int AW = $clog2(MAX_RECTS);
    localparam int CW = $clog2(MAX_RECTS + 1);

    t_state r_state, n_state;

    logic [14:0]   r_width, r_height;
    logic          r_bypass;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_j, n_j;
    logic          r_whole, n_whole;
    logic          r_empty, n_empty;

    t_rect         r_mem [MAX_RECTS];
    t_rect         r_rd_data;

    logic          w_we, w_re;
    logic [AW-1:0] w_waddr, w_raddr;
    t_rect         w_wdata;

    logic          r_o_valid;
    t_rect         r_o_rect;
    logic          r_o_whole, r_o_empty, r_o_last;
    logic          w_load, w_load_whole, w_load_empty, w_load_last;
    t_rect         w_load_rect;

    logic          w_accept, w_slot_free;
    logic          w_full, w_is_empty;
    logic [CW-1:0] w_idx_inc;
    logic [AW-1:0] w_j_dec;
    logic          w_above, w_clear_of, w_miss;
    t_clip         w_clip;
    t_rect         w_new, w_merged, w_full_rect;

    drlm_clip #(
        .ALIGN_MASK_BITS(ALIGN_MASK_BITS)
    ) u_clip (
        .i_clk   (i_clk),
        .i_load  (w_accept),
        .i_edges (t_edges'(i_s_tdata)),
        .i_width (r_width),
        .i_height(r_height),
        .o_res   (w_clip)
    );

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid && o_s_tready;
    assign w_slot_free = !r_o_valid || i_m_tready;

    assign w_new      = w_clip.rect;
    assign w_full     = (r_count >= CW'(MAX_RECTS));
    assign w_is_empty = (r_count == '0);
    assign w_idx_inc  = CW'(r_idx) + CW'(1);
    assign w_j_dec    = r_j - AW'(1);

    // Comparisons of the scanned entry against the new rectangle.
    assign w_above    = (r_rd_data.top > w_new.top);
    assign w_clear_of = (r_rd_data.top > w_new.bottom);
    assign w_miss     = (r_rd_data.bottom < w_new.top);

    assign w_merged.left   = (r_rd_data.left < w_new.left) ? r_rd_data.left : w_new.left;
    assign w_merged.right  = (r_rd_data.right > w_new.right) ? r_rd_data.right : w_new.right;
    assign w_merged.top    = w_above ? w_new.top : r_rd_data.top;
    assign w_merged.bottom = (r_rd_data.bottom > w_new.bottom) ? r_rd_data.bottom
                                                               : w_new.bottom;

    assign w_full_rect.left   = 15'd0;
    assign w_full_rect.top    = 15'd0;
    assign w_full_rect.right  = r_width - 15'd1;
    assign w_full_rect.bottom = r_height - 15'd1;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_s_tuser[0] == CMD_DRAIN) begin
                        n_state = w_is_empty ? ST_EMIT : ST_DRAIN;
                    end else begin
                        n_state = r_bypass ? ST_EMIT : ST_CLIP;
                    end
                end
            end
            ST_CLIP: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                if (w_clip.drop || w_full || w_is_empty) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (w_above && w_clear_of) begin
                    n_state = ST_SHIFT_RD;
                end else if (w_above || !w_miss || w_idx_inc == r_count) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SHIFT_RD: begin
                n_state = ST_SHIFT_WR;
            end
            ST_SHIFT_WR: begin
                n_state = (w_j_dec == r_idx) ? ST_INSERT : ST_SHIFT_RD;
            end
            ST_INSERT: begin
                n_state = ST_IDLE;
            end
            ST_DRAIN: begin
                if (w_slot_free && w_idx_inc == r_count) begin
                    n_state = ST_IDLE;
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Memory control, counters and output register loads.
    always_comb begin
        n_count      = r_count;
        n_idx        = r_idx;
        n_j          = r_j;
        n_whole      = r_whole;
        n_empty      = r_empty;
        w_we         = 1'b0;
        w_waddr      = r_idx;
        w_wdata      = w_new;
        w_re         = 1'b0;
        w_raddr      = '0;
        w_load       = 1'b0;
        w_load_rect  = '0;
        w_load_whole = 1'b0;
        w_load_empty = 1'b0;
        w_load_last  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_idx   = '0;
                    n_whole = (i_s_tuser[0] == CMD_ADD);
                    n_empty = (i_s_tuser[0] == CMD_DRAIN);
                    w_re    = (i_s_tuser[0] == CMD_DRAIN);
                end
            end
            ST_DECIDE: begin
                if (!w_clip.drop) begin
                    if (w_full) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        w_wdata = w_full_rect;
                        n_count = CW'(1);
                    end else if (w_is_empty) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        n_count = CW'(1);
                    end else begin
                        w_re  = 1'b1;
                        n_idx = '0;
                    end
                end
            end
            ST_SCAN: begin
                if (w_above && w_clear_of) begin
                    n_j = r_count[AW-1:0];
                end else if (w_above || !w_miss) begin
                    w_we    = 1'b1;
                    w_wdata = w_merged;
                end else if (w_idx_inc == r_count) begin
                    // Ran past every entry: append at the end.
                    w_we    = 1'b1;
                    w_waddr = r_count[AW-1:0];
                    n_count = r_count + CW'(1);
                end else begin
                    w_re    = 1'b1;
                    w_raddr = w_idx_inc[AW-1:0];
                    n_idx   = w_idx_inc[AW-1:0];
                end
            end
            ST_SHIFT_RD: begin
                w_re    = 1'b1;
                w_raddr = w_j_dec;
            end
            ST_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = r_j;
                w_wdata = r_rd_data;
                n_j     = w_j_dec;
            end
            ST_INSERT: begin
                w_we    = 1'b1;
                n_count = r_count + CW'(1);
            end
            ST_DRAIN: begin
                if (w_slot_free) begin
                    w_load      = 1'b1;
                    w_load_rect = r_rd_data;
                    w_load_last = (w_idx_inc == r_count);
                    if (w_idx_inc == r_count) begin
                        n_count = '0;
                    end else begin
                        w_re    = 1'b1;
                        w_raddr = w_idx_inc[AW-1:0];
                        n_idx   = w_idx_inc[AW-1:0];
                    end
                end
            end
            ST_EMIT: begin
                if (w_slot_free) begin
                    w_load       = 1'b1;
                    w_load_whole = r_whole;
                    w_load_empty = r_empty;
                    w_load_last  = 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
            r_width   <= WIDTH_RESET;
            r_height  <= HEIGHT_RESET;
            r_bypass  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_load) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WIDTH:  r_width  <= i_cfg_data;
                    CFG_HEIGHT: r_height <= i_cfg_data;
                    CFG_BYPASS: r_bypass <= i_cfg_data[0];
                    default:    r_bypass <= r_bypass;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_j     <= n_j;
        r_whole <= n_whole;
        r_empty <= n_empty;
        if (w_load) begin
            r_o_rect  <= w_load_rect;
            r_o_whole <= w_load_whole;
            r_o_empty <= w_load_empty;
            r_o_last  <= w_load_last;
        end
    end

    // Rectangle memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {4'b0000, r_o_rect};
    assign o_m_tuser  = {r_o_empty, r_o_whole};
    assign o_m_tlast  = r_o_last;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECTS))
        else $error("rectangle count exceeds the list depth");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |-> (!r_o_valid || i_m_tready))
        else $error("pending result overwritten");

    a_drain_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN && w_load && w_load_last) |=> (r_count == '0))
        else $error("list not emptied after final drain result");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INSERT) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("insertion did not grow the list");

    a_write_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (CW'(w_waddr) <= r_count))
        else $error("memory write beyond the end of the list");

endmodule

FILE: test/drlm_list_checker.sv
// Checker for the dirty rectangle list merger: keeps its own copy of the
// rectangle list, predicts every report and compares it with the master side.
// Depends on drlm_pkg for the packed request and rectangle layouts.
`timescale 1ns / 1ps

module drlm_list_checker #(
    parameter int MAX_RECTS       = 30,
    parameter int ALIGN_MASK_BITS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [63:0] i_s_tdata,   // left[15:0], top[31:16], right[47:32], bottom[63:48]
    input  logic [0:0]  i_s_tuser,   // command[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,   // out_left[14:0], out_top[29:15], out_right[44:30],
                                     // out_bottom[59:45], zero[63:60]
    input  logic [1:0]  i_m_tuser,   // whole_screen[0], list_empty[1]
    input  logic        i_m_tlast,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [14:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import drlm_pkg::*;

    typedef struct packed {
        t_rect rect;
        logic  whole_screen;
        logic  list_empty;
        logic  last;
    } t_report;

    localparam int COLUMN_MASK = (1 << ALIGN_MASK_BITS) - 1;

    int      dirty_left   [MAX_RECTS];
    int      dirty_top    [MAX_RECTS];
    int      dirty_right  [MAX_RECTS];
    int      dirty_bottom [MAX_RECTS];
    int      dirty_count  = 0;
    int      surf_w       = 320;
    int      surf_h       = 200;
    logic    bypass       = 1'b0;
    t_report pending_reports [$];
    int      pending_count = 0;
    int      fail_count    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    function automatic void queue_report(int l, int t, int r, int b,
                                         logic whole, logic empty, logic last);
        t_report rep;
        rep.rect.left    = 15'(l);
        rep.rect.top     = 15'(t);
        rep.rect.right   = 15'(r);
        rep.rect.bottom  = 15'(b);
        rep.whole_screen = whole;
        rep.list_empty   = empty;
        rep.last         = last;
        pending_reports.push_back(rep);
    endfunction

    function automatic void put_dirty(int i, int l, int t, int r, int b);
        dirty_left[i]   = l;
        dirty_top[i]    = t;
        dirty_right[i]  = r;
        dirty_bottom[i] = b;
    endfunction

    function automatic void grow_dirty(int i, int l, int r, int b);
        if (dirty_bottom[i] < b) dirty_bottom[i] = b;
        if (dirty_left[i] > l) dirty_left[i] = l;
        if (dirty_right[i] < r) dirty_right[i] = r;
    endfunction

    // Clip, align and fold one rectangle into the list kept in top order.
    function automatic void record_dirty_rect(int l, int t, int r, int b);
        int wlim, hlim, swap, i, j;
        wlim = surf_w - 1;
        hlim = surf_h - 1;
        if (l > r) begin
            swap = l; l = r; r = swap;
        end
        if (t > b) begin
            swap = t; t = b; b = swap;
        end
        if (surf_w == 0 || surf_h == 0) return;
        if (l > wlim || r < 0 || t > hlim || b < 0) return;
        if (dirty_count >= MAX_RECTS) begin
            put_dirty(0, 0, 0, wlim, hlim);
            dirty_count = 1;
            return;
        end
        if (l < 0) l = 0;
        if (r > wlim) r = wlim;
        if (t < 0) t = 0;
        if (b > hlim) b = hlim;
        l = l & ~COLUMN_MASK;
        r = r | COLUMN_MASK;
        for (i = 0; i < dirty_count; i++) begin
            if (dirty_top[i] > t) begin
                if (dirty_top[i] > b) begin
                    for (j = dirty_count; j > i; j--)
                        put_dirty(j, dirty_left[j - 1], dirty_top[j - 1],
                                  dirty_right[j - 1], dirty_bottom[j - 1]);
                    put_dirty(i, l, t, r, b);
                    dirty_count++;
                    return;
                end
                grow_dirty(i, l, r, b);
                dirty_top[i] = t;
                return;
            end
            if (dirty_bottom[i] >= t) begin
                grow_dirty(i, l, r, b);
                return;
            end
        end
        put_dirty(dirty_count, l, t, r, b);
        dirty_count++;
    endfunction

    function automatic void drain_list();
        int k;
        if (dirty_count == 0) begin
            queue_report(0, 0, 0, 0, 1'b0, 1'b1, 1'b1);
        end else begin
            for (k = 0; k < dirty_count; k++)
                queue_report(dirty_left[k], dirty_top[k], dirty_right[k], dirty_bottom[k],
                             1'b0, 1'b0, k == dirty_count - 1);
        end
        dirty_count = 0;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_edges  req;
        t_rect   got;
        t_report want;
        if (!i_rst_n) begin
            dirty_count = 0;
            surf_w      = int'(WIDTH_RESET);
            surf_h      = int'(HEIGHT_RESET);
            bypass      = 1'b0;
            pending_reports.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WIDTH:  surf_w = int'(i_cfg_data);
                    CFG_HEIGHT: surf_h = int'(i_cfg_data);
                    CFG_BYPASS: bypass = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready) begin
                req = t_edges'(i_s_tdata);
                if (i_s_tuser[0] == CMD_ADD) begin
                    if (bypass)
                        queue_report(0, 0, 0, 0, 1'b1, 1'b0, 1'b1);
                    else
                        record_dirty_rect(int'($signed(req.left)), int'($signed(req.top)),
                                          int'($signed(req.right)),
                                          int'($signed(req.bottom)));
                end else begin
                    drain_list();
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got = t_rect'(i_m_tdata[59:0]);
                if (pending_reports.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected report, expected none, actual %h/%b/%b",
                             $time, i_m_tdata, i_m_tuser, i_m_tlast);
                end else begin
                    want = pending_reports.pop_front();
                    check_field("out_left", int'(want.rect.left), int'(got.left));
                    check_field("out_top", int'(want.rect.top), int'(got.top));
                    check_field("out_right", int'(want.rect.right), int'(got.right));
                    check_field("out_bottom", int'(want.rect.bottom), int'(got.bottom));
                    check_field("whole_screen", int'(want.whole_screen),
                                int'(i_m_tuser[0]));
                    check_field("list_empty", int'(want.list_empty), int'(i_m_tuser[1]));
                    check_field("last_of_run", int'(want.last), int'(i_m_tlast));
                end
            end
        end
        pending_count = pending_reports.size();
    end

endmodule

FILE: test/tb_dirty_rect_list_merger.sv
// Stimulus and verdict for the dirty rectangle list merger: directed requests,
// then randomised add bursts and drains over several surface settings.
// Depends on drlm_pkg, dirty_rect_list_merger and drlm_list_checker.
`timescale 1ns / 1ps

module tb_dirty_rect_list_merger;
    import drlm_pkg::*;

    localparam logic [1:0] CFG_SPARE     = 2'd3;
    localparam int         QUIET_CYCLES  = 120;
    localparam int         RX_HOLD_CYCLES = 300;
    localparam int         WATCHDOG_LIMIT = 2000;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic [63:0] s_tdata   = '0;
    logic [0:0]  s_tuser   = '0;
    logic        m_tready  = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [14:0] cfg_data  = '0;
    logic        s_tready;
    logic        m_tvalid;
    logic [63:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_ready;
    int          fail_count;
    int          pending;

    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_seq = 0;
    int cur_w       = 320;
    int cur_h       = 200;
    int idle_cycles = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    dirty_rect_list_merger dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .o_m_tlast   (m_tlast),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    drlm_list_checker list_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_m_tlast    (m_tlast),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Receiver: random back-pressure, or one long hold-off whenever asked.
    initial begin
        int hold_seen;
        hold_seen = 0;
        forever begin
            @(negedge clk);
            if (hold_seen != rx_hold_seq) begin
                hold_seen = rx_hold_seq;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [15:0] to_edge(int v);
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[15:0];
    endfunction

    function automatic int noise_edge();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    task automatic send_request(logic cmd, int l, int t, int r, int b);
        int     gap;
        t_edges req;
        gap = 0;
        while (gap < 12 && $urandom_range(99) < tx_idle_pct) gap++;
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req.left   = to_edge(l);
        req.top    = to_edge(t);
        req.right  = to_edge(r);
        req.bottom = to_edge(b);
        s_tdata  <= req;
        s_tuser  <= cmd;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic send_add(int l, int t, int r, int b);
        send_request(CMD_ADD, l, t, r, b);
    endtask

    // A drain ignores the edges, so they carry noise.
    task automatic send_drain();
        send_request(CMD_DRAIN, noise_edge(), noise_edge(), noise_edge(), noise_edge());
    endtask

    task automatic await_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    // An add leaves nothing to wait for, so a quiet stretch covers its latency.
    task automatic write_reg(logic [1:0] index, logic [14:0] value);
        await_results();
        repeat (QUIET_CYCLES) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (index == CFG_WIDTH) cur_w = value;
        if (index == CFG_HEIGHT) cur_h = value;
    endtask

    task automatic set_surface(int w, int h, logic bypass);
        write_reg(CFG_WIDTH, 15'(w));
        write_reg(CFG_HEIGHT, 15'(h));
        write_reg(CFG_BYPASS, {14'd0, bypass});
    endtask

    task automatic random_add(int span_h);
        int w, h, l, t, r, b, tmp;
        w = (cur_w > 0) ? cur_w : 1;
        h = (cur_h > 0) ? cur_h : 1;
        case ($urandom_range(9))
            0: begin
                l = noise_edge();
                t = noise_edge();
                r = noise_edge();
                b = noise_edge();
            end
            1: begin
                // Straddles or misses the surface borders.
                l = int'($urandom_range(w + 63)) - 32;
                t = int'($urandom_range(h + 63)) - 32;
                r = l + int'($urandom_range(80)) - 16;
                b = t + int'($urandom_range(span_h + 16)) - 8;
            end
            default: begin
                l = int'($urandom_range(w - 1));
                r = l + int'($urandom_range(63));
                t = int'($urandom_range(h - 1));
                b = t + int'($urandom_range(span_h));
            end
        endcase
        if ($urandom_range(3) == 0) begin
            tmp = l; l = r; r = tmp;
            tmp = t; t = b; b = tmp;
        end
        send_add(l, t, r, b);
    endtask

    task automatic run_burst(int n, int span_h, int drain_pct);
        repeat (n) begin
            if ($urandom_range(99) < drain_pct)
                send_drain();
            else
                random_add(span_h);
            if ($urandom_range(99) < 6) await_results();
        end
        send_drain();
    endtask

    initial begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 26;
        rx_idle_pct = 58;
        // Directed requests on the reset surface of 320 by 200.
        send_drain();
        send_add(-32768, -32768, 32767, 32767);
        send_drain();
        send_add(100, 150, 20, 40);
        send_add(5, 10, 30, 20);
        send_add(200, 100, 250, 180);
        send_add(0, 5, 8, 45);
        send_add(50, 190, 60, 199);
        send_add(400, 0, 500, 10);
        send_add(-50, 0, -10, 10);
        send_add(0, 300, 10, 400);
        send_add(0, -20, 10, -5);
        send_add(319, 199, 319, 199);
        // Stall the receiver so that the drain blocks further requests.
        rx_hold_seq++;
        send_drain();
        send_add(0, 0, 0, 0);
        send_add(-1, -1, 0, 0);
        send_drain();
        write_reg(CFG_BYPASS, 15'd1);
        send_add(10, 10, 20, 20);
        send_add(-32768, 32767, 32767, -32768);
        send_drain();
        write_reg(CFG_BYPASS, 15'd0);

        set_surface(300, 1, 1'b0);
        run_burst(20, 2, 15);

        tx_idle_pct = 58;
        rx_idle_pct = 26;
        // Tall surface and thin rectangles so the list fills and collapses.
        set_surface(32767, 32767, 1'b0);
        run_burst(40, 3, 0);
        rx_hold_seq++;
        run_burst(20, 200, 15);
        set_surface(1, 32767, 1'b0);
        run_burst(15, 500, 20);

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_surface(640, 480, 1'b1);
        run_burst(15, 40, 20);
        set_surface(0, 200, 1'b0);
        run_burst(10, 20, 30);
        set_surface(200, 0, 1'b0);
        run_burst(8, 20, 30);
        write_reg(CFG_SPARE, 15'($urandom));
        set_surface(320, 200, 1'b0);
        run_burst(20, 40, 15);

        await_results();
        repeat (QUIET_CYCLES) @(negedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/drlm_pkg.sv
rtl/core/drlm_clip.sv
rtl/core/dirty_rect_list_merger.sv
test/drlm_list_checker.sv
test/tb_dirty_rect_list_merger.sv
